// ===== design/lpg_pkg.sv =====
// Shared types, constants and helpers for the lidar point gate and tilt fix block.
// No dependencies.
package lpg_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned QUOT_BITS  = 33;
    localparam int unsigned TILT_SHIFT = 30;

    localparam logic [61:0] MIN_SQ_RST = 62'd0;
    localparam logic [61:0] MAX_SQ_RST = 62'd42949672960000;

    // cos and sin of 0.205 degrees, 30 fraction bits
    localparam logic signed [31:0] TILT_COS = 32'sd1073734951;
    localparam logic signed [23:0] TILT_SIN = 24'sd3841759;

    typedef enum logic [1:0] {
        REG_MIN_RANGE = 2'd0,
        REG_MAX_RANGE = 2'd1,
        REG_TILT_EN   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic               tilt_en;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [63:0]        r2;
    } lpg_item_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m;
    endfunction

endpackage

// ===== design/lpg_front.sv =====
// Front end: configuration registers, point intake, squared-norm range gate.
// Depends on lpg_pkg; pushes kept points into lpg_queue.
module lpg_front #(
    parameter int unsigned DEPTH = lpg_pkg::QUEUE_DEPTH,
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [31:0]    point_x,
    input  logic signed [31:0]    point_y,
    input  logic signed [31:0]    point_z,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  logic [CW-1:0]         q_count,
    output logic                  push,
    output lpg_pkg::lpg_item_t    push_data
);

    logic               vf_reg;
    logic [61:0]        min_sq_reg;
    logic [61:0]        max_sq_reg;
    logic               tilt_en_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic               acc;
    logic [31:0]        ax, ay, az;
    logic [63:0]        r2, n2;
    logic               keep;

    // room is reserved for the transaction held in the intake register
    assign in_stall = ((CW + 1)'(q_count) + (CW + 1)'(vf_reg)) >= (CW + 1)'(DEPTH);
    assign acc      = in_valid && !in_stall;

    assign ax = lpg_pkg::mag32(point_x);
    assign ay = lpg_pkg::mag32(point_y);
    assign az = lpg_pkg::mag32(point_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg      <= 1'b0;
            min_sq_reg  <= lpg_pkg::MIN_SQ_RST;
            max_sq_reg  <= lpg_pkg::MAX_SQ_RST;
            tilt_en_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= acc;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lpg_pkg::REG_MIN_RANGE: min_sq_reg  <= 62'(cfg_data) * 62'(cfg_data);
                    lpg_pkg::REG_MAX_RANGE: max_sq_reg  <= 62'(cfg_data) * 62'(cfg_data);
                    lpg_pkg::REG_TILT_EN:   tilt_en_reg <= cfg_data[0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            x_reg   <= point_x;
            y_reg   <= point_y;
            z_reg   <= point_z;
            sqx_reg <= 64'(ax) * 64'(ax);
            sqy_reg <= 64'(ay) * 64'(ay);
            sqz_reg <= 64'(az) * 64'(az);
        end
    end

    assign r2   = sqx_reg + sqy_reg;
    assign n2   = r2 + sqz_reg;
    assign keep = (n2 > 64'(min_sq_reg)) && (n2 < 64'(max_sq_reg));
    assign push = vf_reg && keep;

    assign push_data.tilt_en = tilt_en_reg;
    assign push_data.x       = x_reg;
    assign push_data.y       = y_reg;
    assign push_data.z       = z_reg;
    assign push_data.r2      = r2;

endmodule

// ===== design/lpg_queue.sv =====
// Short FIFO between the range gate and the correction pipeline.
// Depends on lpg_pkg for the entry type.
module lpg_queue #(
    parameter int unsigned DEPTH = lpg_pkg::QUEUE_DEPTH,
    localparam int unsigned CW = $clog2(DEPTH + 1),
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lpg_pkg::lpg_item_t   push_data,
    input  logic                 pop,
    output lpg_pkg::lpg_item_t   head,
    output logic [CW-1:0]        count,
    output logic                 empty
);

    lpg_pkg::lpg_item_t mem [0:DEPTH-1];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;
    assign empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/lpg_back.sv =====
// Back end: rounded root of x^2+y^2, rounded quotients xz/r and yz/r, optional rotation.
// Depends on lpg_pkg; pops from lpg_queue, drives the output register.
module lpg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  lpg_pkg::lpg_item_t   q_head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [31:0]   out_z
);

    localparam int SQ_N = lpg_pkg::SQRT_STEPS;
    localparam int QB   = lpg_pkg::QUOT_BITS;
    localparam int RT   = SQ_N + 1;
    localparam int DV   = RT + 1;
    localparam int PR   = DV + QB + 1;
    localparam int NS   = PR + 1;
    localparam int SH   = lpg_pkg::TILT_SHIFT;

    typedef struct packed {
        logic               tilt_en;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } meta_t;

    function automatic logic [31:0] round_sat(input logic signed [64:0] v);
        logic [64:0] mag;
        logic [65:0] rs;
        logic [35:0] m;
        logic [31:0] res;
        mag = v[64] ? 65'(-v) : 65'(v);
        rs  = {1'b0, mag} + (66'd1 << (SH - 1));
        m   = rs[SH+35:SH];
        if (v[64])
        begin
            if (m > 36'h080000000)
                m = 36'h080000000;
            res = 32'(-m);
        end
        else
        begin
            if (m > 36'h07FFFFFFF)
                m = 36'h07FFFFFFF;
            res = m[31:0];
        end
        return res;
    endfunction

    logic adv;
    logic v_reg [0:NS-1];
    meta_t m_reg [0:NS-1];
    logic out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;

    logic [63:0] sq_rest_reg [0:SQ_N];
    logic [63:0] sq_res_reg  [0:SQ_N];
    logic [31:0] rp_reg      [RT:PR-1];
    logic [63:0] mx_reg, my_reg;
    logic [63:0] dx_rem_reg [0:QB];
    logic [63:0] dy_rem_reg [0:QB];
    logic [QB-1:0] dx_q_reg [0:QB];
    logic [QB-1:0] dy_q_reg [0:QB];

    logic signed [62:0] pcx_reg, pcy_reg, pcz_reg;
    logic signed [56:0] psx_reg, psy_reg;
    logic [53:0]        prs_reg;

    logic [31:0] root_next;
    logic [31:0] r_pr;
    logic        neg_x, neg_y;
    logic signed [33:0] qx, qy;
    meta_t       mp, mo;
    logic signed [64:0] sum_x, sum_y, sum_z;

    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                v_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= !q_empty;
            for (int k = 1; k < NS; k++)
                v_reg[k] <= v_reg[k-1];
            out_valid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0]       <= '{q_head.tilt_en, q_head.x, q_head.y, q_head.z};
            sq_rest_reg[0] <= q_head.r2;
            sq_res_reg[0]  <= '0;
            for (int k = 1; k < NS; k++)
                m_reg[k] <= m_reg[k-1];
        end
    end

    // square root, one result bit per stage
    for (genvar i = 1; i <= SQ_N; i++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_N - i));
        logic [63:0] t;
        logic        ge;
        assign t  = sq_res_reg[i-1] + BIT;
        assign ge = sq_rest_reg[i-1] >= t;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rest_reg[i] <= ge ? sq_rest_reg[i-1] - t : sq_rest_reg[i-1];
                sq_res_reg[i]  <= ge ? (sq_res_reg[i-1] >> 1) + BIT : sq_res_reg[i-1] >> 1;
            end
        end
    end

    assign root_next = 32'(sq_res_reg[SQ_N] +
                           64'(sq_rest_reg[SQ_N] > sq_res_reg[SQ_N]));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg[RT] <= root_next;
            for (int k = RT + 1; k < PR; k++)
                rp_reg[k] <= rp_reg[k-1];
            mx_reg <= 64'(lpg_pkg::mag32(m_reg[SQ_N].x)) * 64'(lpg_pkg::mag32(m_reg[SQ_N].z));
            my_reg <= 64'(lpg_pkg::mag32(m_reg[SQ_N].y)) * 64'(lpg_pkg::mag32(m_reg[SQ_N].z));
            dx_rem_reg[0] <= mx_reg + 64'(rp_reg[RT] >> 1);
            dy_rem_reg[0] <= my_reg + 64'(rp_reg[RT] >> 1);
            dx_q_reg[0]   <= '0;
            dy_q_reg[0]   <= '0;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        localparam int K = QB - j;
        logic [64:0] d;
        logic        gex, gey;
        assign d   = 65'(rp_reg[DV+j-1]) << K;
        assign gex = {1'b0, dx_rem_reg[j-1]} >= d;
        assign gey = {1'b0, dy_rem_reg[j-1]} >= d;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dx_rem_reg[j] <= gex ? dx_rem_reg[j-1] - d[63:0] : dx_rem_reg[j-1];
                dy_rem_reg[j] <= gey ? dy_rem_reg[j-1] - d[63:0] : dy_rem_reg[j-1];
                dx_q_reg[j]   <= dx_q_reg[j-1] | (gex ? QB'(1) << K : '0);
                dy_q_reg[j]   <= dy_q_reg[j-1] | (gey ? QB'(1) << K : '0);
            end
        end
    end

    assign mp    = m_reg[PR-1];
    assign r_pr  = rp_reg[PR-1];
    assign neg_x = mp.x[31] ^ mp.z[31];
    assign neg_y = mp.y[31] ^ mp.z[31];
    assign qx = (r_pr == '0) ? '0 :
                (neg_x ? -$signed({1'b0, dx_q_reg[QB]}) : $signed({1'b0, dx_q_reg[QB]}));
    assign qy = (r_pr == '0) ? '0 :
                (neg_y ? -$signed({1'b0, dy_q_reg[QB]}) : $signed({1'b0, dy_q_reg[QB]}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pcx_reg <= 63'(mp.x) * 63'(lpg_pkg::TILT_COS);
            pcy_reg <= 63'(mp.y) * 63'(lpg_pkg::TILT_COS);
            pcz_reg <= 63'(mp.z) * 63'(lpg_pkg::TILT_COS);
            psx_reg <= 57'(qx) * 57'(lpg_pkg::TILT_SIN);
            psy_reg <= 57'(qy) * 57'(lpg_pkg::TILT_SIN);
            prs_reg <= 54'(r_pr) * 54'(lpg_pkg::TILT_SIN);
        end
    end

    assign mo    = m_reg[PR];
    assign sum_x = 65'(pcx_reg) - 65'(psx_reg);
    assign sum_y = 65'(pcy_reg) - 65'(psy_reg);
    assign sum_z = 65'(pcz_reg) + 65'($signed({1'b0, prs_reg}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg <= mo.tilt_en ? round_sat(sum_x) : mo.x;
            out_y_reg <= mo.tilt_en ? round_sat(sum_y) : mo.y;
            out_z_reg <= mo.tilt_en ? round_sat(sum_z) : mo.z;
        end
    end

endmodule

// ===== design/lidar_point_gate_and_tilt_fix_top.sv =====
// Top level of the lidar point range gate with vertical tilt correction.
// Depends on lpg_pkg, lpg_front, lpg_queue and lpg_back.
//
// Takes one point per cycle and delivers kept points one per cycle, in order,
// unless stalled. A kept point passes the intake register, the queue, the
// 32-stage square-root pipeline and the 33-stage quotient pipelines of the
// back end. Points outside the open range (min_range, max_range) are dropped.
// An output stall holds the whole back end; the queue then fills and the input
// stalls once the queue and intake register hold QUEUE_DEPTH points.
module lidar_point_gate_and_tilt_fix_top #(
    parameter int unsigned QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic               push, pop, q_empty;
    logic [CW-1:0]      q_count;
    lpg_pkg::lpg_item_t push_data, q_head;

    lpg_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    lpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .count     (q_count),
        .empty     (q_empty)
    );

    lpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

endmodule

// ===== design/lpg_checker.sv =====
// Port-level checks for lidar_point_gate_and_tilt_fix_top, with its bind.
// Depends only on the top level's ports.
module lpg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z
);

    logic [31:0] pend_reg, pend_next;
    logic        in_acc, out_acc;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign pend_next = pend_reg + 32'(in_acc) - 32'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
                                   && $stable(out_z))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pend_reg != '0)
        else $error("result without a pending transaction");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> pend_reg != '0)
        else $error("input stalled with nothing in flight");

endmodule

bind lidar_point_gate_and_tilt_fix_top lpg_checker u_lpg_checker (.*);
